// ----- sv/lur_pkg.sv -----
// Shared constants for the longest unique run finder.
// No dependencies; imported by longest_unique_run_finder.
package lur_pkg;

  // Default width of string positions
  localparam int LUR_POS_BITS = 16;

  // Byte alphabet and table depth
  localparam int LUR_CH_BITS  = 8;
  localparam int LUR_DEPTH    = 1 << LUR_CH_BITS;

  // Result field widths on the output stream
  localparam int LUR_START_W  = 16;
  localparam int LUR_LEN_W    = 17;
  localparam int LUR_OUT_W    = 40;

endpackage

// ----- sv/longest_unique_run_finder.sv -----
// Longest repeat-free run finder: top level with last-seen position memory.
// Depends on lur_pkg.
//
//  channel | dir | tdata                   | tuser      | tlast
//  --------+-----+-------------------------+------------+-----------------
//  s_      | in  | [7:0] ch                | -          | last byte of string
//  m_      | out | [15:0] best_start,      | [0]        | -
//          |     | [32:16] best_len        | overflow   |
//
// One byte is taken every cycle. For each byte the position memory is
// read into a register on acceptance, and the check, the window update
// and the write back happen in the check stage that follows, with the
// previous byte's write forwarded. A final byte loads the output register,
// which lets further bytes in while it waits. Only a final byte blocked by a
// full, stalled output register holds up the input. Reset is synchronous;
// the seen bits clear at once and the memory needs no clearing pass.
module longest_unique_run_finder
  import lur_pkg::*;
#(
  parameter int POS_BITS = LUR_POS_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [LUR_CH_BITS-1:0] s_tdata,   // [7:0] ch
  input  logic                   s_tlast,   // last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [LUR_OUT_W-1:0]   m_tdata,   // [15:0] best_start, [32:16] best_len
  output logic                   m_tuser    // [0] overflow
);

  localparam int LW = POS_BITS + 1;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Position memory and seen bits
  logic [POS_BITS-1:0]  last_position [LUR_DEPTH];
  logic [LUR_DEPTH-1:0] seen_valid;
  logic [POS_BITS-1:0]  rd_data;

  // Search state
  logic [POS_BITS-1:0] index_count;
  logic [POS_BITS-1:0] window_start;
  logic [LW-1:0]       best_length;
  logic [POS_BITS-1:0] best_begin;
  logic                overflow_flag;

  // Check stage
  logic                   s1_valid;
  logic [LUR_CH_BITS-1:0] s1_ch;
  logic                   s1_last;

  // Last write, for forwarding
  logic                   prev_wr;
  logic [LUR_CH_BITS-1:0] prev_ch;
  logic [POS_BITS-1:0]    prev_pos;

  logic                in_accept;
  logic                s1_fire;
  logic [POS_BITS-1:0] pos_rd;
  logic                hit;
  logic [LW-1:0]       len1;
  logic                take1;
  logic [LW-1:0]       best1_len;
  logic [POS_BITS-1:0] best1_beg;
  logic [POS_BITS-1:0] ws1;
  logic [LW-1:0]       len2;
  logic                take2;
  logic [LW-1:0]       fin_len;
  logic [POS_BITS-1:0] fin_beg;

  // Handshake: the check stage stalls only on a final byte with the output full
  assign s1_fire   = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_fire;
  assign in_accept = s_tvalid && s_tready;

  // Read the position memory on acceptance
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= last_position[s_tdata];
    end
    if (s1_fire && !overflow_flag) begin
      last_position[s1_ch] <= index_count;
    end
  end

  // Forward the write that coincided with the read
  assign pos_rd = (prev_wr && prev_ch == s1_ch) ? prev_pos : rd_data;

  // Close the window on a repeat inside it
  assign hit       = !overflow_flag && seen_valid[s1_ch] && (pos_rd >= window_start);
  assign len1      = {1'b0, index_count} - {1'b0, window_start};
  assign take1     = hit && (best_length < len1);
  assign best1_len = take1 ? len1 : best_length;
  assign best1_beg = take1 ? window_start : best_begin;
  assign ws1       = hit ? (pos_rd + 1'b1) : window_start;

  // Offer the open window on the final byte
  assign len2    = {1'b0, index_count} + LW'(1) - {1'b0, ws1};
  assign take2   = best1_len < len2;
  assign fin_len = take2 ? len2 : best1_len;
  assign fin_beg = take2 ? ws1 : best1_beg;

  // Advance the check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_ch   <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  // Update search state, seen bits and forwarding record
  always_ff @(posedge clk) begin
    if (rst) begin
      index_count   <= '0;
      window_start  <= '0;
      best_length   <= '0;
      best_begin    <= '0;
      overflow_flag <= 1'b0;
      seen_valid    <= '0;
      prev_wr       <= 1'b0;
    end else if (s1_fire) begin
      prev_wr  <= !overflow_flag;
      prev_ch  <= s1_ch;
      prev_pos <= index_count;
      if (s1_last) begin
        index_count   <= '0;
        window_start  <= '0;
        best_length   <= '0;
        best_begin    <= '0;
        overflow_flag <= 1'b0;
        seen_valid    <= '0;
      end else if (!overflow_flag) begin
        window_start       <= ws1;
        best_length        <= best1_len;
        best_begin         <= best1_beg;
        seen_valid[s1_ch]  <= 1'b1;
        if (index_count == POS_MAX) begin
          overflow_flag <= 1'b1;
        end else begin
          index_count <= index_count + 1'b1;
        end
      end
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      m_tdata <= {{(LUR_OUT_W - LUR_LEN_W - LUR_START_W){1'b0}},
                  LUR_LEN_W'(fin_len), LUR_START_W'(fin_beg)};
      m_tuser <= overflow_flag;
    end
  end

`ifndef ASSERT_OFF
  // A blocked final byte must hold the input back
  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while final byte is blocked");

  // A finished string leaves no seen bit behind
  a_seen_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (seen_valid == '0))
    else $error("seen bits not cleared after final byte");

  // The window never starts beyond the current byte
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    window_start <= index_count)
    else $error("window start beyond index");

  // A result appears only after a final byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_fire && s1_last))
    else $error("result without final byte");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for longest_unique_run_finder: byte strings in, one run summary out.
// Depends on lur_pkg and the block itself; a local tracker predicts every random result.
module testbench;
  import lur_pkg::*;

  localparam int POS_BITS  = LUR_POS_BITS;
  localparam int LIMIT     = 1_000_000;
  localparam int N_RANDOM  = 1200;
  localparam int HOLD_LONG = 400;

  // One run summary as it leaves the block
  typedef struct packed {
    logic [LUR_START_W-1:0] start;
    logic [LUR_LEN_W-1:0]   len;
    logic                   ovf;
  } run_t;

  // One directed request, with the summary typed in on final bytes
  typedef struct packed {
    logic [LUR_CH_BITS-1:0] ch;
    logic                   fin;
    logic                   typed;
    run_t                   want;
  } dir_row_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // single byte string
    '{8'h41, 1'b1, 1'b1, '{16'd0, 17'd1, 1'b0}},
    // lowest and highest byte values
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{16'd0, 17'd2, 1'b0}},
    // all bytes equal: equal windows keep the first
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, '{16'd0, 17'd1, 1'b0}},
    // alternating pair, table must be clear after the previous string
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h42, 1'b1, 1'b1, '{16'd0, 17'd2, 1'b0}},
    // later window is strictly longer and replaces the best
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h44, 1'b0, 1'b0, '0},
    '{8'h45, 1'b1, 1'b1, '{16'd1, 17'd5, 1'b0}},
    // earlier occurrence left behind the window start is not a repeat
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h41, 1'b1, 1'b1, '{16'd0, 17'd3, 1'b0}}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [LUR_CH_BITS-1:0] s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [LUR_OUT_W-1:0]   m_tdata;
  logic                   m_tuser;

  longest_unique_run_finder #(.POS_BITS(POS_BITS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run tracker state
  logic [POS_BITS-1:0] last_at [LUR_DEPTH];
  bit                  byte_seen [LUR_DEPTH];
  logic [POS_BITS-1:0] pos_idx;
  logic [POS_BITS:0]   win_start;
  logic [POS_BITS:0]   best_run;
  logic [POS_BITS-1:0] best_at;
  bit                  ovf_flag;

  run_t runs_due [$];
  int   byte_count;
  int   run_checks;
  int   mismatch_count;
  int   string_count;
  bit   calm;
  bit   tx_quiet;
  bit   rx_hold_req;

  task automatic clear_tracker();
    foreach (byte_seen[i]) byte_seen[i] = 1'b0;
    pos_idx   = '0;
    win_start = '0;
    best_run  = '0;
    best_at   = '0;
    ovf_flag  = 1'b0;
  endtask

  // Close a window ending just before end_pos; only a strictly longer one wins
  task automatic offer_run(input logic [POS_BITS:0] end_pos);
    logic [POS_BITS:0] len;
    len = end_pos - win_start;
    if (best_run < len) begin
      best_run = len;
      best_at  = win_start[POS_BITS-1:0];
    end
  endtask

  // Advance the tracker by one byte; a final byte yields the run summary
  task automatic track_byte(input logic [LUR_CH_BITS-1:0] c, input logic fin,
                            output bit got, output run_t res);
    logic [POS_BITS-1:0] p;
    p   = pos_idx;
    got = 1'b0;
    res = '0;
    if (!ovf_flag) begin
      if (byte_seen[c] && {1'b0, last_at[c]} >= win_start) begin
        offer_run({1'b0, p});
        win_start = {1'b0, last_at[c]} + 1'b1;
      end
      last_at[c]   = p;
      byte_seen[c] = 1'b1;
    end
    if (!fin) begin
      if (!ovf_flag) begin
        if (p == {POS_BITS{1'b1}})
          ovf_flag = 1'b1;
        else
          pos_idx = p + 1'b1;
      end
    end else begin
      offer_run({1'b0, p} + 1'b1);
      res.start = LUR_START_W'(best_at);
      res.len   = LUR_LEN_W'(best_run);
      res.ovf   = ovf_flag;
      got       = 1'b1;
      clear_tracker();
    end
  endtask

  // Offer one byte, wait for the handshake, then queue what it should produce
  task automatic send_byte(input logic [LUR_CH_BITS-1:0] c, input logic fin,
                           input logic typed, input run_t want);
    bit   got;
    run_t res;
    @(negedge clk);
    if (!calm && !tx_quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    byte_count++;
    track_byte(c, fin, got, res);
    if (got) begin
      runs_due.push_back(typed ? want : res);
      string_count++;
    end
  endtask

  // Send one whole string of random bytes from a window of the alphabet
  task automatic send_string(input int len, input int span);
    logic [LUR_CH_BITS-1:0] base;
    base = LUR_CH_BITS'($urandom_range(0, LUR_DEPTH - 1));
    for (int i = 0; i < len; i++)
      send_byte(base + LUR_CH_BITS'($urandom_range(0, span - 1)), i == len - 1, 1'b0, '0);
  endtask

  // Receiver: random stall bursts, quiet stretches and one long hold-off
  initial begin : receiver
    int  stall_left;
    int  hold_left;
    bit  rx_quiet;
    bit  hold_done;
    stall_left = 0;
    hold_left  = 0;
    rx_quiet   = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LONG;
      end
      if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0 && !calm) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = 0;
        if (!calm && !rx_quiet && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Compare each summary leaving the block with the oldest one due
  always @(posedge clk) begin
    run_t got_run;
    run_t due;
    if (!rst && m_tvalid && m_tready) begin
      got_run.start = m_tdata[LUR_START_W-1:0];
      got_run.len   = m_tdata[LUR_START_W +: LUR_LEN_W];
      got_run.ovf   = m_tuser;
      if (runs_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: start %0d len %0d ovf %0b",
                   got_run.start, got_run.len, got_run.ovf);
        mismatch_count++;
      end else begin
        due = runs_due.pop_front();
        run_checks++;
        if (got_run.start !== due.start || got_run.len !== due.len ||
            got_run.ovf !== due.ovf) begin
          if (mismatch_count < 10)
            $display("mismatch: start %0d/%0d len %0d/%0d ovf %0b/%0b (expected/actual)",
                     due.start, got_run.start, due.len, got_run.len, due.ovf, got_run.ovf);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    int drain;
    int span_pick;
    byte_count     = 0;
    run_checks     = 0;
    mismatch_count = 0;
    string_count   = 0;
    calm           = 1'b0;
    tx_quiet       = 1'b0;
    rx_hold_req    = 1'b0;
    clear_tracker();

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings
    for (int i = 0; i < N_DIR; i++)
      send_byte(DIRECTED[i].ch, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);

    // Random strings; the receiver holds off for a long stretch early on
    rx_hold_req = 1'b1;
    while (byte_count < N_RANDOM + N_DIR) begin
      if (byte_count > N_RANDOM * 5 / 6 + N_DIR) calm = 1'b1;
      tx_quiet  = ($urandom_range(0, 3) == 0);
      span_pick = $urandom_range(0, 3);
      send_string(($urandom_range(0, 15) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40),
                  (span_pick == 0) ? 2 : (span_pick == 1) ? 5 :
                  (span_pick == 2) ? 26 : LUR_DEPTH);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain the outstanding summaries, then let the pipeline settle
    drain = 0;
    while (runs_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    mismatch_count += runs_due.size();

    $display("covered %0d strings over %0d bytes, %0d summaries compared",
             string_count, byte_count, run_checks);
    $display("including hand-made edge strings, idle bursts and a long output stall");
    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
